FILE: hw/rtl/bpm_pkg.sv
package bpm_pkg;

  // defaults for the top level parameters
  localparam int unsigned DefMaxPattern = 256;
  localparam int unsigned DefOffsetBits = 32;

  // fixed field widths
  localparam int unsigned LenW  = 9;
  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 8;
  localparam int unsigned PosW  = 32;

  // input word kinds
  localparam logic KindPattern = 1'b0;
  localparam logic KindData    = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StCmp,
    StDone
  } bpm_state_e;

endpackage

FILE: hw/rtl/bpm_if.sv
interface bpm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [bpm_pkg::ByteW-1:0]  byte_value;
  logic [bpm_pkg::IdxW-1:0]   pattern_index;
  logic                       last_byte;

  modport source (
    output valid, kind, byte_value, pattern_index, last_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, byte_value, pattern_index, last_byte,
    output ready
  );
endinterface

interface bpm_out_if;
  logic                      valid;
  logic                      ready;
  logic [bpm_pkg::PosW-1:0]  match_position;

  modport source (
    output valid, match_position,
    input  ready
  );
  modport sink (
    input  valid, match_position,
    output ready
  );
endinterface

FILE: hw/rtl/byte_pattern_match_stream.sv
// Streaming byte pattern search. Pattern bytes are loaded by index (kind 0) and data
// bytes (kind 1) are pushed into a circular window memory; after each data byte the
// newest pattern_length bytes are compared against the pattern store one byte per
// cycle through the single read port of each memory, and a hit puts the buffer offset
// of the match start on the output channel. A pattern write or a data byte that
// cannot complete a match is taken at once; a data byte that is compared holds off
// further input until its compare of up to pattern_length bytes ends, with the length
// capped at the store depth (sooner when a mismatch stops the compare early), and on a
// hit until a previous result still held at the output is taken. A data byte with
// last_byte set ends the buffer and clears the offset and fill count. No memory
// clearing is needed after reset.
module byte_pattern_match_stream #(
  parameter int unsigned MAX_PATTERN = bpm_pkg::DefMaxPattern,
  parameter int unsigned OFFSET_BITS = bpm_pkg::DefOffsetBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bpm_pkg::LenW-1:0] cfg_wdata_i,
  bpm_in_if.sink                   in_i,
  bpm_out_if.source                out_o
);
  import bpm_pkg::*;

  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam logic [AW-1:0] LastAddr = AW'(MAX_PATTERN - 1);
  localparam logic [LW-1:0] MaxLen   = LW'(MAX_PATTERN);

  bpm_state_e state_q, state_d;

  logic [LenW-1:0]        len_q;
  logic [LW-1:0]          fill_q, fill_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [LW-1:0]          clen_q;
  logic [LW-1:0]          cnt_q;
  logic [AW-1:0]          waddr_q;
  logic                   rvalid_q;
  logic                   ok_q;
  logic [PosW-1:0]        pos_q;
  logic                   out_valid_q;
  logic [PosW-1:0]        out_pos_q;

  logic                   in_ready;
  logic                   accept;
  logic                   pat_we;
  logic                   push;
  logic                   issue;
  logic                   cmp_done;
  logic                   load_out;
  logic                   hit_possible;
  logic [LW-1:0]          ulen;
  logic [LW-1:0]          lm1;
  logic [AW-1:0]          lm1_a;
  logic [LW-1:0]          fill_inc;
  logic                   off_sat;
  logic [OFFSET_BITS-1:0] start_off;
  logic [OFFSET_BITS+PosW-1:0] start_ext;
  logic [AW+IdxW-1:0]     pidx_ext;
  logic [AW-1:0]          push_ptr;
  logic [AW:0]            sa_lo, sa_hi;
  logic [AW-1:0]          start_addr;
  logic [AW-1:0]          waddr_nxt;
  logic [ByteW-1:0]       pat_rd;
  logic [ByteW-1:0]       win_rd;

  bpm_pat_mem #(
    .MAX_PATTERN (MAX_PATTERN),
    .AW          (AW)
  ) u_pat_mem (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pidx_ext[AW-1:0]),
    .wdata_i (in_i.byte_value),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (pat_rd)
  );

  bpm_win_mem #(
    .MAX_PATTERN (MAX_PATTERN),
    .AW          (AW)
  ) u_win_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_byte_i (in_i.byte_value),
    .push_ptr_o  (push_ptr),
    .rd_addr_i   (waddr_q),
    .rd_data_o   (win_rd)
  );

  // accept side
  assign accept   = in_i.valid && in_ready;
  assign pidx_ext = {{AW{1'b0}}, in_i.pattern_index};
  assign pat_we   = accept && (in_i.kind == KindPattern) && (32'(in_i.pattern_index) < MAX_PATTERN);
  assign push     = accept && (in_i.kind == KindData);

  assign ulen     = (32'(len_q) > MAX_PATTERN) ? MaxLen : LW'(len_q);
  assign lm1      = ulen - LW'(1);
  assign lm1_a    = AW'(lm1);
  assign fill_inc = (fill_q == MaxLen) ? fill_q : fill_q + LW'(1);
  assign off_sat  = &offset_q;
  assign hit_possible = (ulen != '0) && (fill_inc >= ulen) && !off_sat;

  assign start_off = offset_q - (OFFSET_BITS'(ulen) - OFFSET_BITS'(1));
  assign start_ext = {{PosW{1'b0}}, start_off};

  // oldest byte of the candidate match, modulo the window depth
  assign sa_lo      = {1'b0, push_ptr} - {1'b0, lm1_a};
  assign sa_hi      = {1'b0, push_ptr} + (AW+1)'(MAX_PATTERN) - {1'b0, lm1_a};
  assign start_addr = (push_ptr >= lm1_a) ? sa_lo[AW-1:0] : sa_hi[AW-1:0];

  assign waddr_nxt = (waddr_q == LastAddr) ? '0 : waddr_q + AW'(1);

  always_comb begin
    if (in_i.last_byte) begin
      fill_d   = '0;
      offset_d = '0;
    end else begin
      fill_d   = fill_inc;
      offset_d = off_sat ? offset_q : offset_q + OFFSET_BITS'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (push && hit_possible) begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        if (cmp_done) begin
          state_d = ok_q ? StDone : StIdle;
        end
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    cmp_done = 1'b0;
    load_out = 1'b0;
    case (state_q)
      StIdle: in_ready = 1'b1;
      StCmp: begin
        issue    = (cnt_q < clen_q) && ok_q;
        cmp_done = !issue && !rvalid_q;
      end
      StDone: load_out = !out_valid_q || out_o.ready;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= LenW'(1);
      fill_q      <= '0;
      offset_q    <= '0;
      cnt_q       <= '0;
      rvalid_q    <= 1'b0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (push) begin
        fill_q   <= fill_d;
        offset_q <= offset_d;
        cnt_q    <= '0;
        ok_q     <= 1'b1;
      end else begin
        if (issue) begin
          cnt_q <= cnt_q + LW'(1);
        end
        if (rvalid_q && (pat_rd != win_rd)) begin
          ok_q <= 1'b0;
        end
      end
      rvalid_q <= issue;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      clen_q  <= ulen;
      waddr_q <= start_addr;
      pos_q   <= start_ext[PosW-1:0];
    end else if (issue) begin
      waddr_q <= waddr_nxt;
    end
    if (load_out) begin
      out_pos_q <= pos_q;
    end
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.match_position = out_pos_q;

endmodule

FILE: hw/rtl/bpm_pat_mem.sv
module bpm_pat_mem #(
  parameter int unsigned MAX_PATTERN = bpm_pkg::DefMaxPattern,
  parameter int unsigned AW          = 8
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [bpm_pkg::ByteW-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [bpm_pkg::ByteW-1:0] rdata_o
);
  import bpm_pkg::*;

  logic [ByteW-1:0] mem [MAX_PATTERN];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bpm_win_mem.sv
module bpm_win_mem #(
  parameter int unsigned MAX_PATTERN = bpm_pkg::DefMaxPattern,
  parameter int unsigned AW          = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [bpm_pkg::ByteW-1:0] push_byte_i,
  output logic [AW-1:0]             push_ptr_o,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [bpm_pkg::ByteW-1:0] rd_data_o
);
  import bpm_pkg::*;

  localparam logic [AW-1:0] LastAddr = AW'(MAX_PATTERN - 1);

  // circular buffer, head_q holds the newest byte
  logic [ByteW-1:0] mem [MAX_PATTERN];
  logic [ByteW-1:0] rd_data_q;
  logic [AW-1:0]    head_q;
  logic [AW-1:0]    head_d;

  assign head_d     = (head_q == LastAddr) ? '0 : head_q + AW'(1);
  assign push_ptr_o = head_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (push_i) begin
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[head_d] <= push_byte_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: tb/sv/tb_byte_pattern_match_stream.sv
module tb_byte_pattern_match_stream;
  timeunit 1ns;
  timeprecision 1ps;

  import bpm_pkg::*;

  localparam int unsigned PatDepth = DefMaxPattern;
  localparam longint unsigned OffsetMax = (64'd1 << DefOffsetBits) - 64'd1;

  typedef logic [ByteW-1:0] byte_t;

  typedef struct packed {
    logic              kind;
    byte_t             value;
    logic [IdxW-1:0]   index;
    logic              is_last;
  } in_word_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [LenW-1:0] cfg_wdata_i;

  bpm_in_if  in_if ();
  bpm_out_if out_if ();

  byte_pattern_match_stream u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if.sink),
    .out_o       (out_if.source)
  );

  // search state mirrored by the testbench
  byte_t           pat_mem [PatDepth];
  byte_t           win_mem [PatDepth];
  int unsigned     win_fill;
  longint unsigned buf_offset;
  logic [LenW-1:0] pat_len;

  logic [PosW-1:0] match_pos_q [$];
  int unsigned     mismatch_cnt = 0;

  int unsigned burst_left   = 0;
  bit          src_idle_en  = 1'b0;
  bit          snk_stall_en = 1'b0;
  bit          rdy_on       = 1'b0;
  int unsigned rdy_left     = 0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int unsigned eff_len();
    return (pat_len > PatDepth) ? PatDepth : int'(pat_len);
  endfunction

  // shift a data word into the window and queue the match start, if any
  function automatic void predict_match(input byte_t b, input logic is_last);
    int unsigned len;
    bit          hit;
    len = eff_len();
    for (int k = PatDepth - 1; k > 0; k--) win_mem[k] = win_mem[k - 1];
    win_mem[0] = b;
    if (win_fill < PatDepth) win_fill++;
    if (buf_offset < OffsetMax) begin
      hit = (len != 0) && (win_fill >= len);
      for (int j = 0; j < int'(len) && hit; j++) begin
        if (win_mem[len - 1 - j] != pat_mem[j]) hit = 1'b0;
      end
      if (hit) match_pos_q.push_back(PosW'(buf_offset - (len - 1)));
      buf_offset++;
    end
    if (is_last) begin
      buf_offset = 0;
      win_fill   = 0;
    end
  endfunction

  task automatic send_word(input in_word_t w);
    if (src_idle_en && burst_left == 0) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    in_if.valid         = 1'b1;
    in_if.kind          = w.kind;
    in_if.byte_value    = w.value;
    in_if.pattern_index = w.index;
    in_if.last_byte     = w.is_last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (w.kind == KindPattern) pat_mem[w.index] = w.value;
    else predict_match(w.value, w.is_last);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic feed_byte(input byte_t b, input logic is_last);
    send_word('{KindData, b, IdxW'($urandom), is_last});
  endtask

  // last_byte is don't-care on a pattern word, so toggle it freely
  task automatic load_pat(input int unsigned idx, input byte_t b);
    send_word('{KindPattern, b, IdxW'(idx), 1'($urandom)});
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (match_pos_q.size() != 0) @(posedge clk_i);
    // non-matching words may still be in the compare loop
    repeat (eff_len() + 8) @(posedge clk_i);
  endtask

  task automatic set_pattern_length(input logic [LenW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    pat_len  = v;
  endtask

  // receiver: alternating ready and stall stretches when stalls are enabled
  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_on   = !rdy_on;
      rdy_left = rdy_on ? $urandom_range(1, 16) : $urandom_range(1, 8);
    end
    rdy_left--;
    out_if.ready = snk_stall_en ? rdy_on : 1'b1;
  end

  always @(posedge clk_i) begin
    logic [PosW-1:0] want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (match_pos_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected match_position %0d", $time, out_if.match_position);
      end else begin
        want = match_pos_q.pop_front();
        if (out_if.match_position !== want) begin
          mismatch_cnt++;
          $display("%0t: match_position expected %0d got %0d",
                   $time, want, out_if.match_position);
        end
      end
    end
  end

  // length 1 out of reset, pattern word with last set mid-buffer
  task automatic test_reset_length();
    src_idle_en  = 1'b1;
    snk_stall_en = 1'b1;
    send_word('{KindPattern, 8'hFF, 8'd0, 1'b0});
    feed_byte(8'h00, 1'b0);
    feed_byte(8'hFF, 1'b0);
    send_word('{KindPattern, 8'hFF, 8'd0, 1'b1});
    feed_byte(8'hFF, 1'b1);
    feed_byte(8'hFF, 1'b0);
    feed_byte(8'h00, 1'b1);
  endtask

  // overlapping hits, hit on the final word, fill cleared by last
  task automatic test_overlap_and_buffer_end();
    set_pattern_length(LenW'(3));
    send_word('{KindPattern, 8'h00, 8'd0, 1'b1});
    send_word('{KindPattern, 8'hFF, 8'd1, 1'b0});
    send_word('{KindPattern, 8'h00, 8'd2, 1'b1});
    feed_byte(8'h00, 1'b0);
    feed_byte(8'hFF, 1'b0);
    feed_byte(8'h00, 1'b0);
    feed_byte(8'hFF, 1'b0);
    feed_byte(8'h00, 1'b1);
    feed_byte(8'hFF, 1'b0);
    feed_byte(8'h00, 1'b1);
  endtask

  task automatic test_zero_length();
    set_pattern_length(LenW'(0));
    feed_byte(8'h00, 1'b0);
    feed_byte(8'h00, 1'b0);
    feed_byte(8'hFF, 1'b1);
  endtask

  task automatic test_load_store();
    src_idle_en  = 1'b0;
    snk_stall_en = 1'b0;
    for (int i = 0; i < PatDepth; i++) load_pat(i, byte_t'($urandom));
  endtask

  // full store length, then a length beyond the store
  task automatic test_long_pattern();
    src_idle_en  = 1'b1;
    snk_stall_en = 1'b1;
    set_pattern_length(LenW'(PatDepth));
    repeat (3) feed_byte(byte_t'($urandom), 1'b0);
    for (int i = 0; i < PatDepth; i++) feed_byte(pat_mem[i], i == PatDepth - 1);
    set_pattern_length('1);
    for (int i = 0; i < PatDepth; i++) feed_byte(pat_mem[i], 1'b0);
    feed_byte(byte_t'($urandom), 1'b0);
    feed_byte(byte_t'($urandom), 1'b1);
  endtask

  // short patterns over a small alphabet so hits are frequent
  task automatic test_random_streams();
    int unsigned len;
    int unsigned sent;
    int unsigned pick;
    byte_t       alpha [3];
    for (int ph = 0; ph < 12; ph++) begin
      src_idle_en  = (ph % 3) != 0;
      snk_stall_en = (ph % 4) != 0;
      len = (ph % 4 == 3) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      set_pattern_length(LenW'(len));
      foreach (alpha[k]) alpha[k] = byte_t'($urandom);
      for (int i = 0; i < int'(len); i++) load_pat(i, alpha[$urandom_range(0, 2)]);
      sent = 0;
      while (sent < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          for (int i = 0; i < int'(len); i++)
            feed_byte(pat_mem[i], $urandom_range(0, 39) == 0);
          sent += len;
        end else if (pick < 80) begin
          feed_byte(alpha[$urandom_range(0, 2)], $urandom_range(0, 24) == 0);
          sent++;
        end else if (pick < 90) begin
          feed_byte(byte_t'($urandom), $urandom_range(0, 24) == 0);
          sent++;
        end else if (pick < 96) begin
          // pattern changes under a live stream
          load_pat($urandom_range(0, len - 1), alpha[$urandom_range(0, 2)]);
          sent++;
        end else begin
          load_pat($urandom_range(0, PatDepth - 1), byte_t'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    in_if.valid         = 1'b0;
    in_if.kind          = KindData;
    in_if.byte_value    = '0;
    in_if.pattern_index = '0;
    in_if.last_byte     = 1'b0;
    foreach (pat_mem[k]) pat_mem[k] = '0;
    foreach (win_mem[k]) win_mem[k] = '0;
    win_fill   = 0;
    buf_offset = 0;
    pat_len    = LenW'(1);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_length();
    test_overlap_and_buffer_end();
    test_zero_length();
    test_load_store();
    test_long_pattern();
    test_random_streams();

    drain();
    if (mismatch_cnt == 0 && match_pos_q.size() == 0) begin
      $display("tb_byte_pattern_match_stream: PASS");
    end else begin
      $display("tb_byte_pattern_match_stream: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_byte_pattern_match_stream: FAIL");
    $finish;
  end

endmodule
